FILE: design/sfp_pkg.sv
// Shared constants, status codes and the result record of the status frame parser.
package sfp_pkg;

    localparam int unsigned COUNT_W = 6;

    localparam logic [COUNT_W-1:0] FRAME_LEN     = 6'd51;
    localparam logic [COUNT_W-1:0] HDR_POS_A     = 6'd0;
    localparam logic [COUNT_W-1:0] HDR_POS_B     = 6'd1;
    localparam logic [COUNT_W-1:0] TRL_POS_A     = 6'd49;
    localparam logic [COUNT_W-1:0] TRL_POS_B     = 6'd50;
    localparam logic [COUNT_W-1:0] XOR_FIRST     = 6'd2;
    localparam logic [COUNT_W-1:0] XOR_LAST      = 6'd47;
    localparam logic [COUNT_W-1:0] CHECK_POS     = 6'd48;
    localparam logic [COUNT_W-1:0] FOCUS_BASE    = 6'd10;
    localparam logic [COUNT_W-1:0] AZIMUTH_BASE  = 6'd28;
    localparam logic [COUNT_W-1:0] ELEV_BASE     = 6'd32;

    localparam logic [7:0] MARK_A = 8'h1F;
    localparam logic [7:0] MARK_B = 8'hF1;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_SHORT       = 3'd1;
    localparam logic [2:0] ST_BAD_HEADER  = 3'd2;
    localparam logic [2:0] ST_BAD_TRAILER = 3'd3;
    localparam logic [2:0] ST_BAD_CHECK   = 3'd4;

    typedef struct packed {
        logic [2:0]  frame_status;
        logic [31:0] azimuth_bits;
        logic [31:0] elevation_bits;
        logic [31:0] vis_focus;
    } result_t;

endpackage

FILE: design/sfp_frame_check.sv
// Per-datagram accumulation: byte count, header and trailer checks, XOR sum and word capture.
module sfp_frame_check (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             byte_accept,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    output sfp_pkg::result_t result
);
    import sfp_pkg::*;

    logic [COUNT_W-1:0] byte_count_reg,  byte_count_next;
    logic [7:0]         running_xor_reg, running_xor_next;
    logic               header_bad_reg,  header_bad_next;
    logic               trailer_bad_reg, trailer_bad_next;
    logic [7:0]         check_byte_reg,  check_byte_next;
    logic [31:0]        azimuth_reg,     azimuth_next;
    logic [31:0]        elevation_reg,   elevation_next;
    logic [31:0]        focus_reg,       focus_next;
    logic               in_frame;
    logic [COUNT_W-1:0] pos;
    logic [COUNT_W-1:0] foc_off, azi_off, elv_off;
    logic [2:0]         status;

    assign pos      = byte_count_reg;
    assign in_frame = (pos < FRAME_LEN);
    assign foc_off  = pos - FOCUS_BASE;
    assign azi_off  = pos - AZIMUTH_BASE;
    assign elv_off  = pos - ELEV_BASE;

    always_comb begin
        byte_count_next  = byte_count_reg;
        running_xor_next = running_xor_reg;
        header_bad_next  = header_bad_reg;
        trailer_bad_next = trailer_bad_reg;
        check_byte_next  = check_byte_reg;
        azimuth_next     = azimuth_reg;
        elevation_next   = elevation_reg;
        focus_next       = focus_reg;
        if (in_frame) begin
            if (pos == HDR_POS_A && data_byte != MARK_A) header_bad_next  = 1'b1;
            if (pos == HDR_POS_B && data_byte != MARK_B) header_bad_next  = 1'b1;
            if (pos == TRL_POS_A && data_byte != MARK_B) trailer_bad_next = 1'b1;
            if (pos == TRL_POS_B && data_byte != MARK_A) trailer_bad_next = 1'b1;
            if (pos >= XOR_FIRST && pos <= XOR_LAST) begin
                running_xor_next = running_xor_reg ^ data_byte;
            end
            if (pos == CHECK_POS) check_byte_next = data_byte;
            if (pos >= FOCUS_BASE && foc_off < 6'd4) begin
                focus_next[foc_off[1:0]*8 +: 8] = data_byte;
            end
            if (pos >= AZIMUTH_BASE && azi_off < 6'd4) begin
                azimuth_next[azi_off[1:0]*8 +: 8] = data_byte;
            end
            if (pos >= ELEV_BASE && elv_off < 6'd4) begin
                elevation_next[elv_off[1:0]*8 +: 8] = data_byte;
            end
            byte_count_next = pos + 6'd1;
        end
    end

    // Status in priority order, taken from the state including this byte.
    always_comb begin
        if (byte_count_next < FRAME_LEN)            status = ST_SHORT;
        else if (header_bad_next)                   status = ST_BAD_HEADER;
        else if (trailer_bad_next)                  status = ST_BAD_TRAILER;
        else if (running_xor_next != check_byte_next) status = ST_BAD_CHECK;
        else                                        status = ST_OK;
    end

    always_comb begin
        result.frame_status   = status;
        result.azimuth_bits   = (status == ST_OK) ? azimuth_next   : 32'd0;
        result.elevation_bits = (status == ST_OK) ? elevation_next : 32'd0;
        result.vis_focus      = (status == ST_OK) ? focus_next     : 32'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (byte_accept && last_byte)) begin
            byte_count_reg  <= '0;
            running_xor_reg <= '0;
            header_bad_reg  <= 1'b0;
            trailer_bad_reg <= 1'b0;
            check_byte_reg  <= '0;
            azimuth_reg     <= '0;
            elevation_reg   <= '0;
            focus_reg       <= '0;
        end else if (byte_accept) begin
            byte_count_reg  <= byte_count_next;
            running_xor_reg <= running_xor_next;
            header_bad_reg  <= header_bad_next;
            trailer_bad_reg <= trailer_bad_next;
            check_byte_reg  <= check_byte_next;
            azimuth_reg     <= azimuth_next;
            elevation_reg   <= elevation_next;
            focus_reg       <= focus_next;
        end
    end

endmodule

FILE: design/status_frame_parser_unit.sv
// Top level of the status frame parser: byte input channel, frame checker and result buffer.
//
// The unit takes one status datagram byte per transaction on the s_ channel and, on the byte
// flagged by s_last_byte, delivers one result transaction on the m_ channel: a status (0 ok,
// 1 shorter than 51 bytes, 2 bad header, 3 bad trailer, 4 checksum mismatch, first failing
// check wins) and the azimuth, elevation and visible focus words captured little-endian from
// offsets 28, 32 and 10, which read as zero unless the status is ok. Bytes past offset 50 are
// ignored. Throughput is one byte per clock while s_ready is high: the checker state updates in
// the cycle a byte is accepted, and the result is registered in the output or skid register.
// Results sit in a two-entry buffer (output register plus skid register), so bytes keep flowing
// while a result waits; s_ready drops only when both entries hold results that have not been
// taken. State clears after each last byte, so the next byte starts a new datagram.
module status_frame_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_frame_status,
    output logic [31:0] m_azimuth_bits,
    output logic [31:0] m_elevation_bits,
    output logic [31:0] m_vis_focus
);
    import sfp_pkg::*;

    logic    s_accept;
    logic    new_result;
    logic    out_take;
    result_t frame_result;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;

    assign s_ready    = !skid_valid_reg;
    assign s_accept   = s_valid && s_ready;
    assign new_result = s_accept && s_last_byte;
    assign out_take   = out_valid_reg && m_ready;

    sfp_frame_check u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (s_accept),
        .data_byte   (s_data_byte),
        .last_byte   (s_last_byte),
        .result      (frame_result)
    );

    // Result buffer: drain the skid entry first; otherwise load a new result into the output
    // register when it is free or being taken, else park it in the skid register.
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (out_take) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (new_result) begin
            if (!out_valid_reg || m_ready) begin
                out_data_next  = frame_result;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next  = frame_result;
                skid_valid_next = 1'b1;
            end
        end else if (out_take) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_frame_status   = out_data_reg.frame_status;
    assign m_azimuth_bits   = out_data_reg.azimuth_bits;
    assign m_elevation_bits = out_data_reg.elevation_bits;
    assign m_vis_focus      = out_data_reg.vis_focus;

    // The skid entry is only ever occupied behind a full output register.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output register empty");

    // A result that arrives against a stalled output fills the skid entry.
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        !skid_valid_reg && new_result && out_valid_reg && !m_ready |=> skid_valid_reg)
        else $error("result lost while output stalled");

    // A failed frame never carries captured words.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_status != ST_OK) |->
        (m_azimuth_bits == 32'd0 && m_elevation_bits == 32'd0 && m_vis_focus == 32'd0))
        else $error("failed frame shows non-zero words");

    // A result accepted on an empty buffer shows on the output in the next cycle.
    a_result_visible: assert property (@(posedge aclk) disable iff (!aresetn)
        new_result && !out_valid_reg |=> m_valid)
        else $error("result did not reach the output register");

endmodule

FILE: dv/status_frame_parser_unit_tb.sv
// Self-checking testbench for status_frame_parser_unit: directed and random datagrams.
module status_frame_parser_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfp_pkg::*;

    // Run limit, far above the slowest correct run.
    localparam int unsigned RUN_LIMIT_NS = 4_000_000;
    localparam int unsigned LONG_STALL   = 300;
    localparam int unsigned TAIL_CYCLES  = 20;
    localparam int unsigned PHASE_BYTES  = 280;
    localparam int unsigned PHASE_FRAMES = 5;

    // Payload fill for the body bytes of a built datagram.
    typedef enum {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } fill_e;

    // Datagram shapes that the sender can build.
    typedef enum {
        K_GOOD,
        K_LONG,
        K_SHORT,
        K_BAD_HDR0,
        K_BAD_HDR1,
        K_BAD_TRL49,
        K_BAD_TRL50,
        K_BAD_SUM,
        K_BAD_BOTH,
        K_NOISE
    } frame_kind_e;

    // Track one datagram in flight and keep the results it is due to produce.
    class frame_status_scoreboard;
        result_t     awaited_results[$];
        int unsigned mismatches;
        logic [5:0]  byte_pos;
        logic [7:0]  xor_acc;
        logic [7:0]  check_val;
        logic        hdr_fail;
        logic        trl_fail;
        logic [31:0] az_word;
        logic [31:0] el_word;
        logic [31:0] fo_word;

        function new();
            mismatches = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            byte_pos  = '0;
            xor_acc   = '0;
            check_val = '0;
            hdr_fail  = 1'b0;
            trl_fail  = 1'b0;
            az_word   = '0;
            el_word   = '0;
            fo_word   = '0;
        endfunction

        // Advance the datagram state by one accepted byte; queue a result on the last one.
        function void note_byte(logic [7:0] value, logic is_last);
            int      pos;
            result_t res;
            pos = int'(byte_pos);
            if (byte_pos < FRAME_LEN) begin
                if (byte_pos == HDR_POS_A && value != MARK_A) hdr_fail = 1'b1;
                if (byte_pos == HDR_POS_B && value != MARK_B) hdr_fail = 1'b1;
                if (byte_pos == TRL_POS_A && value != MARK_B) trl_fail = 1'b1;
                if (byte_pos == TRL_POS_B && value != MARK_A) trl_fail = 1'b1;
                if (byte_pos >= XOR_FIRST && byte_pos <= XOR_LAST) xor_acc ^= value;
                if (byte_pos == CHECK_POS) check_val = value;
                if (pos >= int'(FOCUS_BASE) && pos < int'(FOCUS_BASE) + 4)
                    fo_word[8*(pos - int'(FOCUS_BASE)) +: 8] = value;
                if (pos >= int'(AZIMUTH_BASE) && pos < int'(AZIMUTH_BASE) + 4)
                    az_word[8*(pos - int'(AZIMUTH_BASE)) +: 8] = value;
                if (pos >= int'(ELEV_BASE) && pos < int'(ELEV_BASE) + 4)
                    el_word[8*(pos - int'(ELEV_BASE)) +: 8] = value;
                byte_pos = byte_pos + 6'd1;
            end
            if (is_last) begin
                if (byte_pos < FRAME_LEN)    res.frame_status = ST_SHORT;
                else if (hdr_fail)           res.frame_status = ST_BAD_HEADER;
                else if (trl_fail)           res.frame_status = ST_BAD_TRAILER;
                else if (xor_acc != check_val) res.frame_status = ST_BAD_CHECK;
                else                         res.frame_status = ST_OK;
                res.azimuth_bits   = (res.frame_status == ST_OK) ? az_word : '0;
                res.elevation_bits = (res.frame_status == ST_OK) ? el_word : '0;
                res.vis_focus      = (res.frame_status == ST_OK) ? fo_word : '0;
                awaited_results.push_back(res);
                clear_frame();
            end
        endfunction

        // Compare one delivered result with the oldest awaited one, field by field.
        function void check_result(result_t got);
            result_t want;
            if (awaited_results.size() == 0) begin
                $error("result with no datagram pending: frame_status %0d", got.frame_status);
                mismatches++;
                return;
            end
            want = awaited_results.pop_front();
            if (got.frame_status !== want.frame_status) begin
                $error("frame_status: expected %0d, got %0d", want.frame_status,
                       got.frame_status);
                mismatches++;
            end
            if (got.azimuth_bits !== want.azimuth_bits) begin
                $error("azimuth_bits: expected %h, got %h", want.azimuth_bits,
                       got.azimuth_bits);
                mismatches++;
            end
            if (got.elevation_bits !== want.elevation_bits) begin
                $error("elevation_bits: expected %h, got %h", want.elevation_bits,
                       got.elevation_bits);
                mismatches++;
            end
            if (got.vis_focus !== want.vis_focus) begin
                $error("vis_focus: expected %h, got %h", want.vis_focus, got.vis_focus);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return awaited_results.size();
        endfunction
    endclass

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [2:0]  m_frame_status;
    logic [31:0] m_azimuth_bits;
    logic [31:0] m_elevation_bits;
    logic [31:0] m_vis_focus;

    // Idle rates in percent, changed by the stimulus between phases.
    int unsigned send_idle_pct = 8;
    int unsigned recv_idle_pct = 67;
    // Set by the stimulus to ask the result sink for one long hold-off.
    bit          stall_req     = 1'b0;

    int unsigned frames_sent = 0;
    int unsigned bytes_sent  = 0;

    frame_status_scoreboard status_sb = new();

    status_frame_parser_unit DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_last_byte      (s_last_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_status   (m_frame_status),
        .m_azimuth_bits   (m_azimuth_bits),
        .m_elevation_bits (m_elevation_bits),
        .m_vis_focus      (m_vis_focus)
    );

    // 20 ns clock.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Offer one byte and hold it until the transaction completes. Handshake signals are
    // sampled at the falling edge, where nothing driven at the rising edge is still moving,
    // and the transaction is taken as done at the rising edge that follows.
    task automatic send_byte(input logic [7:0] value, input logic is_last);
        logic took;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= value;
        s_last_byte <= is_last;
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
        status_sb.note_byte(value, is_last);
    endtask

    // Build one datagram of the given shape and send it byte by byte. For short, long and
    // noise datagrams len is the total length in bytes; other shapes are always 51 bytes.
    task automatic send_frame(input frame_kind_e kind, input fill_e fill,
                              input int unsigned len);
        logic [7:0] frame_bytes[$];
        logic [7:0] body;
        logic [7:0] sum;
        sum = '0;
        frame_bytes = {MARK_A, MARK_B};
        for (int i = 2; i <= 47; i++) begin
            case (fill)
                FILL_ZERO: body = 8'h00;
                FILL_ONES: body = 8'hFF;
                default:   body = 8'($urandom);
            endcase
            sum ^= body;
            frame_bytes.push_back(body);
        end
        frame_bytes.push_back(sum);
        frame_bytes.push_back(MARK_B);
        frame_bytes.push_back(MARK_A);

        // Damage or reshape the well-formed datagram; flip bits with a non-zero mask.
        case (kind)
            K_LONG:      while (frame_bytes.size() < len) frame_bytes.push_back(8'($urandom));
            K_SHORT:     while (frame_bytes.size() > len) void'(frame_bytes.pop_back());
            K_BAD_HDR0:  frame_bytes[0]  ^= 8'($urandom_range(1, 255));
            K_BAD_HDR1:  frame_bytes[1]  ^= 8'($urandom_range(1, 255));
            K_BAD_TRL49: frame_bytes[49] ^= 8'($urandom_range(1, 255));
            K_BAD_TRL50: frame_bytes[50] ^= 8'($urandom_range(1, 255));
            K_BAD_SUM:   frame_bytes[48] ^= 8'($urandom_range(1, 255));
            K_BAD_BOTH: begin
                frame_bytes[0]  ^= 8'($urandom_range(1, 255));
                frame_bytes[50] ^= 8'($urandom_range(1, 255));
            end
            K_NOISE: begin
                frame_bytes.delete();
                repeat (len) frame_bytes.push_back(8'($urandom));
            end
            default: ;
        endcase
        // Let marker faults sometimes coincide with a checksum fault, so the priority of
        // the checks is exercised.
        if (kind inside {K_BAD_HDR0, K_BAD_HDR1, K_BAD_TRL49, K_BAD_TRL50} && $urandom_range(1))
            frame_bytes[48] ^= 8'($urandom_range(1, 255));

        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        frames_sent++;
        bytes_sent += frame_bytes.size();
    endtask

    // Drop the input valid and hold the sender until every awaited result has been
    // delivered.
    task automatic wait_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (status_sb.pending() != 0);
    endtask

    // Result sink: sample the handshake at the falling edge, check at the rising edge,
    // then pick m_ready for the next cycle. A long hold-off is counted here.
    initial begin : result_sink
        int unsigned stall_left;
        logic        took;
        result_t     got;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            took                = m_valid && m_ready;
            got.frame_status    = m_frame_status;
            got.azimuth_bits    = m_azimuth_bits;
            got.elevation_bits  = m_elevation_bits;
            got.vis_focus       = m_vis_focus;
            @(posedge aclk);
            if (took) status_sb.check_result(got);
            if (stall_req) begin
                stall_req  = 1'b0;
                stall_left = LONG_STALL;
            end
            if (stall_left != 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Stimulus: reset, directed datagrams, the pressure sequence, then three random phases.
    initial begin : stimulus
        frame_kind_e kind;
        int unsigned pick;
        int unsigned len;
        int unsigned phase_bytes_base;
        int unsigned phase_frames_base;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: clean datagrams with random, all-zero and all-one bodies.
        send_frame(K_GOOD, FILL_RANDOM, 51);
        send_frame(K_GOOD, FILL_ZERO, 51);
        send_frame(K_GOOD, FILL_ONES, 51);
        // Shortest and longest short datagram.
        send_frame(K_SHORT, FILL_RANDOM, 1);
        send_frame(K_SHORT, FILL_RANDOM, 50);
        // Each marker byte wrong in turn, then a checksum fault.
        send_frame(K_BAD_HDR0, FILL_RANDOM, 51);
        send_frame(K_BAD_HDR1, FILL_RANDOM, 51);
        send_frame(K_BAD_TRL49, FILL_ONES, 51);
        send_frame(K_BAD_TRL50, FILL_ZERO, 51);
        send_frame(K_BAD_SUM, FILL_RANDOM, 51);
        // Header fault must win over a trailer fault.
        send_frame(K_BAD_BOTH, FILL_RANDOM, 51);
        // Long datagrams: one byte over, and well past the counter's natural wrap.
        send_frame(K_LONG, FILL_RANDOM, 52);
        send_frame(K_LONG, FILL_ONES, 130);
        // Short noise: short must win whatever the markers say.
        send_frame(K_NOISE, FILL_RANDOM, 20);

        // Pause the sender until the block has handed everything back.
        wait_drain();

        // Pressure: hold the result side off while one-byte datagrams keep arriving, so
        // the result buffer fills and the input stalls; then release and drain.
        stall_req = 1'b1;
        repeat (12) send_frame(K_SHORT, FILL_RANDOM, 1);
        send_frame(K_GOOD, FILL_RANDOM, 51);
        wait_drain();

        // Random phases: sender 8 / receiver 67, then 67 / 8, then no idling.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 8;
                    recv_idle_pct = 67;
                end
                1: begin
                    send_idle_pct = 67;
                    recv_idle_pct = 8;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_bytes_base  = bytes_sent;
            phase_frames_base = frames_sent;
            while (bytes_sent - phase_bytes_base < PHASE_BYTES ||
                   frames_sent - phase_frames_base < PHASE_FRAMES) begin
                // Mostly well-formed datagrams with random bodies, the rest broken or noise.
                pick = $urandom_range(99);
                len  = 51;
                if (pick < 50) begin
                    kind = K_GOOD;
                end else if (pick < 60) begin
                    kind = K_LONG;
                    len  = $urandom_range(52, 90);
                end else if (pick < 70) begin
                    kind = K_SHORT;
                    len  = $urandom_range(1, 50);
                end else if (pick < 74) begin
                    kind = K_BAD_HDR0;
                end else if (pick < 78) begin
                    kind = K_BAD_HDR1;
                end else if (pick < 82) begin
                    kind = K_BAD_TRL49;
                end else if (pick < 86) begin
                    kind = K_BAD_TRL50;
                end else if (pick < 92) begin
                    kind = K_BAD_SUM;
                end else if (pick < 95) begin
                    kind = K_BAD_BOTH;
                end else begin
                    kind = K_NOISE;
                    len  = $urandom_range(1, 64);
                end
                send_frame(kind, FILL_RANDOM, len);
            end
            wait_drain();
        end

        // Allow for a stray late result before the verdict.
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (status_sb.mismatches == 0 && status_sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Drop the run if it hangs.
    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
design/sfp_pkg.sv
design/sfp_frame_check.sv
design/status_frame_parser_unit.sv
dv/status_frame_parser_unit_tb.sv
